[hdl/aat_pkg.sv]
// ============================================================================
// aat_pkg
// Shared constants and types for the box affine transform pipeline.
// ============================================================================
package aat_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam int COEF_WIDTH_DEF  = 16;

    localparam int COEF_FRAC  = 12;
    localparam int OFS_W      = 32;
    localparam int ROW_W      = 48;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int NUM_AXES   = 3;
    localparam int NUM_STAGES = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_X,
        REG_ROW_Y,
        REG_ROW_Z,
        REG_OFS_XY,
        REG_OFS_Z
    } t_cfg_reg;

    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
    } t_pipe_ctl;

endpackage

[hdl/aat_box_if.sv]
// ============================================================================
// aat_box_if
// Input channel: one box (min and max corners) per beat.
// ============================================================================
interface aat_box_if #(
    parameter int COORD_WIDTH = aat_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] lo_x;
    logic signed [COORD_WIDTH-1:0] lo_y;
    logic signed [COORD_WIDTH-1:0] lo_z;
    logic signed [COORD_WIDTH-1:0] hi_x;
    logic signed [COORD_WIDTH-1:0] hi_y;
    logic signed [COORD_WIDTH-1:0] hi_z;

    modport source (output valid, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, input ready);
    modport sink   (input valid, lo_x, lo_y, lo_z, hi_x, hi_y, hi_z, output ready);
endinterface

[hdl/aat_res_if.sv]
// ============================================================================
// aat_res_if
// Result channel: one transformed box and an overflow flag per beat.
// ============================================================================
interface aat_res_if #(
    parameter int COORD_WIDTH = aat_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] out_lo_x;
    logic signed [COORD_WIDTH-1:0] out_lo_y;
    logic signed [COORD_WIDTH-1:0] out_lo_z;
    logic signed [COORD_WIDTH-1:0] out_hi_x;
    logic signed [COORD_WIDTH-1:0] out_hi_y;
    logic signed [COORD_WIDTH-1:0] out_hi_z;
    logic                          overflow;

    modport source (output valid, out_lo_x, out_lo_y, out_lo_z, out_hi_x, out_hi_y,
                    out_hi_z, overflow, input ready);
    modport sink   (input valid, out_lo_x, out_lo_y, out_lo_z, out_hi_x, out_hi_y,
                    out_hi_z, overflow, output ready);
endinterface

[hdl/aabb_affine_transform.sv]
// ============================================================================
// aabb_affine_transform
// Affine transform of an axis-aligned box (Arvo's method) in fixed point.
// ============================================================================
// Usage:
//   i_box  : valid/ready sink, one box per beat (signed Q16.16 min and max
//            corners). A beat is taken when valid and ready are both high.
//   o_res  : valid/ready source, one transformed box per input beat, in
//            order, with overflow set when any coordinate saturated.
//   i_cfg_*: write port for the matrix rows (Q4.12) and translation
//            (Q16.16); index 0..4 as rows x, y, z, offset xy, offset z.
//            Unknown indexes are dropped. Write only while no box is in
//            flight.
// Throughput is one box per cycle while the receiver holds o_res.ready high,
// set by a five-stage pipeline per output axis (multiply, min/max, two
// adder levels, saturate).
// Reset clears all pipeline valid bits and loads the identity matrix with
// zero translation. When the receiver stalls, each stage holds only while
// the stage after it is full, so bubbles close up and input keeps being
// taken until all five stages hold a box.
// ============================================================================
module aabb_affine_transform #(
    parameter int COORD_WIDTH = aat_pkg::COORD_WIDTH_DEF,
    parameter int COEF_WIDTH  = aat_pkg::COEF_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    aat_box_if.sink                         i_box,
    aat_res_if.source                       o_res,
    input  logic                            i_cfg_we,
    input  logic [aat_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [aat_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import aat_pkg::*;

    localparam int ROW_EXT = (NUM_AXES * COEF_WIDTH > ROW_W) ? NUM_AXES * COEF_WIDTH : ROW_W;

    localparam logic signed [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic [ROW_W-1:0]              row     [NUM_AXES];
    logic [ROW_EXT-1:0]            row_ext [NUM_AXES];
    logic signed [OFS_W-1:0]       ofs     [NUM_AXES];
    logic signed [COEF_WIDTH-1:0]  coef    [NUM_AXES][NUM_AXES];
    logic signed [COORD_WIDTH-1:0] box_lo  [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] box_hi  [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] res_lo  [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] res_hi  [NUM_AXES];
    logic [NUM_AXES-1:0]           res_ovf;

    logic [NUM_STAGES-1:0]         r_vld;
    logic [NUM_STAGES-1:0]         n_vld;
    logic [NUM_STAGES-1:0]         pipe_en;
    t_pipe_ctl                     ctl;

    aat_cfg_regs #(
        .COEF_WIDTH (COEF_WIDTH)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_row      (row),
        .o_ofs      (ofs)
    );

    // coefficient i of row j feeds input axis j into output axis i
    always_comb begin
        for (int j = 0; j < NUM_AXES; j++) begin
            row_ext[j] = ROW_EXT'(row[j]);
            for (int i = 0; i < NUM_AXES; i++) begin
                coef[i][j] = row_ext[j][i*COEF_WIDTH +: COEF_WIDTH];
            end
        end
    end

    assign box_lo[0] = i_box.lo_x;
    assign box_lo[1] = i_box.lo_y;
    assign box_lo[2] = i_box.lo_z;
    assign box_hi[0] = i_box.hi_x;
    assign box_hi[1] = i_box.hi_y;
    assign box_hi[2] = i_box.hi_z;

    // a stage loads when empty or when the next one moves on
    always_comb begin
        pipe_en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || o_res.ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            pipe_en[k] = !r_vld[k] || pipe_en[k+1];
        end
        n_vld  = {r_vld[NUM_STAGES-2:0], i_box.valid};
        ctl.en = pipe_en;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NUM_STAGES; k++) begin
                if (pipe_en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    for (genvar i = 0; i < NUM_AXES; i++) begin : g_axis
        aat_axis #(
            .COORD_WIDTH (COORD_WIDTH),
            .COEF_WIDTH  (COEF_WIDTH)
        ) u_axis (
            .i_clk  (i_clk),
            .i_ctl  (ctl),
            .i_lo   (box_lo),
            .i_hi   (box_hi),
            .i_coef (coef[i]),
            .i_ofs  (ofs[i]),
            .o_lo   (res_lo[i]),
            .o_hi   (res_hi[i]),
            .o_ovf  (res_ovf[i])
        );
    end

    assign i_box.ready    = pipe_en[0];
    assign o_res.valid    = r_vld[NUM_STAGES-1];
    assign o_res.out_lo_x = res_lo[0];
    assign o_res.out_lo_y = res_lo[1];
    assign o_res.out_lo_z = res_lo[2];
    assign o_res.out_hi_x = res_hi[0];
    assign o_res.out_hi_y = res_hi[1];
    assign o_res.out_hi_z = res_hi[2];
    assign o_res.overflow = |res_ovf;

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_box.valid && i_box.ready |=> r_vld[0])
        else $error("accepted beat did not enter the pipeline");

    a_lo_not_above_hi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.out_lo_x <= o_res.out_hi_x) &&
                        (o_res.out_lo_y <= o_res.out_hi_y) &&
                        (o_res.out_lo_z <= o_res.out_hi_z))
        else $error("result min corner above max corner");

    a_ovf_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.overflow |->
            (o_res.out_lo_x == C_MAX) || (o_res.out_lo_x == C_MIN) ||
            (o_res.out_lo_y == C_MAX) || (o_res.out_lo_y == C_MIN) ||
            (o_res.out_lo_z == C_MAX) || (o_res.out_lo_z == C_MIN) ||
            (o_res.out_hi_x == C_MAX) || (o_res.out_hi_x == C_MIN) ||
            (o_res.out_hi_y == C_MAX) || (o_res.out_hi_y == C_MIN) ||
            (o_res.out_hi_z == C_MAX) || (o_res.out_hi_z == C_MIN))
        else $error("overflow flagged without a saturated coordinate");

endmodule

[hdl/aat_axis.sv]
// ============================================================================
// aat_axis
// Datapath for one output axis: multiply, min/max select, two-level add,
// saturate. Five register stages, each loaded by its own stage enable.
// ============================================================================
module aat_axis #(
    parameter int COORD_WIDTH = aat_pkg::COORD_WIDTH_DEF,
    parameter int COEF_WIDTH  = aat_pkg::COEF_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  aat_pkg::t_pipe_ctl                i_ctl,
    input  logic signed [COORD_WIDTH-1:0]     i_lo   [aat_pkg::NUM_AXES],
    input  logic signed [COORD_WIDTH-1:0]     i_hi   [aat_pkg::NUM_AXES],
    input  logic signed [COEF_WIDTH-1:0]      i_coef [aat_pkg::NUM_AXES],
    input  logic signed [aat_pkg::OFS_W-1:0]  i_ofs,
    output logic signed [COORD_WIDTH-1:0]     o_lo,
    output logic signed [COORD_WIDTH-1:0]     o_hi,
    output logic                              o_ovf
);
    import aat_pkg::*;

    localparam int FULL_W = COORD_WIDTH + COEF_WIDTH;
    localparam int PROD_W = FULL_W - COEF_FRAC;
    localparam int SUM_W  = ((PROD_W > OFS_W) ? PROD_W : OFS_W) + 2;

    // stage 0: full products
    logic signed [FULL_W-1:0] r_p_lo [NUM_AXES];
    logic signed [FULL_W-1:0] r_p_hi [NUM_AXES];
    // stage 1: truncated, ordered products
    logic signed [PROD_W-1:0] r_mn [NUM_AXES];
    logic signed [PROD_W-1:0] r_mx [NUM_AXES];
    logic signed [PROD_W-1:0] n_mn [NUM_AXES];
    logic signed [PROD_W-1:0] n_mx [NUM_AXES];
    // stage 2/3: partial and total sums
    logic signed [SUM_W-1:0]  r_lo_a, r_lo_b, r_hi_a, r_hi_b;
    logic signed [SUM_W-1:0]  r_lo_s, r_hi_s;
    // stage 4: saturated result
    logic signed [COORD_WIDTH-1:0] r_lo_q, r_hi_q;
    logic                          r_ovf;
    logic signed [COORD_WIDTH-1:0] n_lo_q, n_hi_q;
    logic                          n_lo_ovf, n_hi_ovf;

    function automatic logic [COORD_WIDTH:0] sat(input logic signed [SUM_W-1:0] v);
        logic [SUM_W-COORD_WIDTH:0] top;
        logic                       fits;
        top  = v[SUM_W-1:COORD_WIDTH-1];
        fits = (&top) || !(|top);
        if (fits) begin
            sat = {1'b0, v[COORD_WIDTH-1:0]};
        end else if (v[SUM_W-1]) begin
            sat = {1'b1, 1'b1, {(COORD_WIDTH-1){1'b0}}};
        end else begin
            sat = {1'b1, 1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            for (int j = 0; j < NUM_AXES; j++) begin
                r_p_lo[j] <= FULL_W'(i_lo[j]) * FULL_W'(i_coef[j]);
                r_p_hi[j] <= FULL_W'(i_hi[j]) * FULL_W'(i_coef[j]);
            end
        end
    end

    // floor to Q16.16 is the arithmetic drop of the low fraction bits
    always_comb begin
        logic signed [PROD_W-1:0] e;
        logic signed [PROD_W-1:0] f;
        for (int j = 0; j < NUM_AXES; j++) begin
            e = r_p_lo[j][FULL_W-1:COEF_FRAC];
            f = r_p_hi[j][FULL_W-1:COEF_FRAC];
            if (e < f) begin
                n_mn[j] = e;
                n_mx[j] = f;
            end else begin
                n_mn[j] = f;
                n_mx[j] = e;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[1]) begin
            r_mn <= n_mn;
            r_mx <= n_mx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[2]) begin
            r_lo_a <= SUM_W'(i_ofs) + SUM_W'(r_mn[0]);
            r_lo_b <= SUM_W'(r_mn[1]) + SUM_W'(r_mn[2]);
            r_hi_a <= SUM_W'(i_ofs) + SUM_W'(r_mx[0]);
            r_hi_b <= SUM_W'(r_mx[1]) + SUM_W'(r_mx[2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[3]) begin
            r_lo_s <= r_lo_a + r_lo_b;
            r_hi_s <= r_hi_a + r_hi_b;
        end
    end

    always_comb begin
        {n_lo_ovf, n_lo_q} = sat(r_lo_s);
        {n_hi_ovf, n_hi_q} = sat(r_hi_s);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[4]) begin
            r_lo_q <= n_lo_q;
            r_hi_q <= n_hi_q;
            r_ovf  <= n_lo_ovf || n_hi_ovf;
        end
    end

    assign o_lo  = r_lo_q;
    assign o_hi  = r_hi_q;
    assign o_ovf = r_ovf;

endmodule

[hdl/aat_box_transform_top_placeholder.sv]
// ============================================================================
// aat_cfg_regs
// Configuration register file: three coefficient rows and the translation.
// ============================================================================
module aat_cfg_regs #(
    parameter int COEF_WIDTH = aat_pkg::COEF_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [aat_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [aat_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic [aat_pkg::ROW_W-1:0]           o_row [aat_pkg::NUM_AXES],
    output logic signed [aat_pkg::OFS_W-1:0]    o_ofs [aat_pkg::NUM_AXES]
);
    import aat_pkg::*;

    logic [ROW_W-1:0]      r_row [NUM_AXES];
    logic [2*OFS_W-1:0]    r_ofs_xy;
    logic [OFS_W-1:0]      r_ofs_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_AXES; k++) begin
                r_row[k] <= ROW_W'(1) << (COEF_FRAC + k * COEF_WIDTH);
            end
            r_ofs_xy <= '0;
            r_ofs_z  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ROW_X:  r_row[0] <= i_cfg_data[ROW_W-1:0];
                REG_ROW_Y:  r_row[1] <= i_cfg_data[ROW_W-1:0];
                REG_ROW_Z:  r_row[2] <= i_cfg_data[ROW_W-1:0];
                REG_OFS_XY: r_ofs_xy <= i_cfg_data[2*OFS_W-1:0];
                REG_OFS_Z:  r_ofs_z  <= i_cfg_data[OFS_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_row    = r_row;
    assign o_ofs[0] = r_ofs_xy[OFS_W-1:0];
    assign o_ofs[1] = r_ofs_xy[2*OFS_W-1:OFS_W];
    assign o_ofs[2] = r_ofs_z;

endmodule
